// ----- rtl/hmbp_pkg.sv -----
// hmbp_pkg: shared types, constants and character helpers for the header message byte parser
// used by hmbp_step, header_message_byte_parser_core and hmbp_checker; no dependencies

package hmbp_pkg;

   // width of the body length counter; the digit accumulator is one bit wider
   localparam int LENGTH_BITS = 16;
   localparam int LEN_ACC_W   = LENGTH_BITS + 1;
   localparam int LEN_PROD_W  = LENGTH_BITS + 5;
   localparam int MAX_LEN_W   = 16;

   localparam int KEY_LEN = 14;
   localparam int KEY_POS_W = 4;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   localparam logic [7:0] LENGTH_KEY [KEY_LEN] = '{
      "c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h"
   };

   // message parts
   localparam logic [2:0] PART_PROTOCOL = 3'd0;
   localparam logic [2:0] PART_METHOD   = 3'd1;
   localparam logic [2:0] PART_NAME     = 3'd2;
   localparam logic [2:0] PART_VALUE    = 3'd3;
   localparam logic [2:0] PART_HDR_END  = 3'd4;
   localparam logic [2:0] PART_BODY     = 3'd5;

   // error codes
   localparam logic [3:0] ERR_NONE         = 4'd0;
   localparam logic [3:0] ERR_PROTO_START  = 4'd1;
   localparam logic [3:0] ERR_PROTO_CHAR   = 4'd2;
   localparam logic [3:0] ERR_METHOD_START = 4'd3;
   localparam logic [3:0] ERR_METHOD_CHAR  = 4'd4;
   localparam logic [3:0] ERR_NO_LF        = 4'd5;
   localparam logic [3:0] ERR_NAME_START   = 4'd6;
   localparam logic [3:0] ERR_NAME_CHAR    = 4'd7;
   localparam logic [3:0] ERR_NO_SPACE     = 4'd8;
   localparam logic [3:0] ERR_VALUE_CHAR   = 4'd9;
   localparam logic [3:0] ERR_DUP_LENGTH   = 4'd10;
   localparam logic [3:0] ERR_BAD_LENGTH   = 4'd11;

   typedef enum logic [9:0] {
      ST_START     = 10'b00_0000_0001,
      ST_PROTO     = 10'b00_0000_0010,
      ST_METHOD    = 10'b00_0000_0100,
      ST_METHOD_LF = 10'b00_0000_1000,
      ST_NAME      = 10'b00_0001_0000,
      ST_COLON_SP  = 10'b00_0010_0000,
      ST_VALUE     = 10'b00_0100_0000,
      ST_VALUE_LF  = 10'b00_1000_0000,
      ST_END_LF    = 10'b01_0000_0000,
      ST_BODY      = 10'b10_0000_0000
   } parse_state_type;

   typedef struct packed {
      parse_state_type        parse_state;
      logic                   at_token_start;
      logic                   length_seen;
      logic [KEY_POS_W-1:0]   name_match_pos;
      logic                   name_mismatch;
      logic                   value_is_length;
      logic [LEN_ACC_W-1:0]   length_value;
      logic                   value_bad;
      logic [LENGTH_BITS-1:0] body_remaining;
   } parser_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] part;
      logic       token_end;
      logic       packet_end;
      logic [3:0] error_code;
   } result_type;

   localparam parser_type PARSER_RESET = '{
      parse_state:     ST_START,
      at_token_start:  1'b0,
      length_seen:     1'b0,
      name_match_pos:  '0,
      name_mismatch:   1'b0,
      value_is_length: 1'b0,
      length_value:    '0,
      value_bad:       1'b0,
      body_remaining:  '0
   };

   function automatic logic is_cap(input logic [7:0] c);
      return (c >= "A") && (c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return is_cap(c) || ((c >= "a") && (c <= "z"));
   endfunction

   function automatic logic is_cap_dig_us(input logic [7:0] c);
      return is_cap(c) || is_digit(c) || (c == "_");
   endfunction

   function automatic logic is_name_char(input logic [7:0] c);
      return is_letter(c) || is_digit(c) || (c == "_") || (c == "-");
   endfunction

   function automatic logic is_printable(input logic [7:0] c);
      return (c >= 8'h20) && (c <= 8'h7E);
   endfunction

endpackage

// ----- rtl/hmbp_step.sv -----
// hmbp_step: next-state and result logic for one byte of the header message parser
// depends on hmbp_pkg

module hmbp_step (
   input  logic [7:0]                    in_byte,
   input  logic [hmbp_pkg::MAX_LEN_W-1:0] max_body_length,
   input  hmbp_pkg::parser_type          cur,
   output hmbp_pkg::parser_type          nxt,
   output hmbp_pkg::result_type          res
);

   logic [3:0]                          err;
   logic                                tok;
   logic                                pkt;
   logic [2:0]                          part;
   logic                                key_hit;
   logic [hmbp_pkg::LEN_PROD_W-1:0]     acc_prod;
   logic [hmbp_pkg::LEN_PROD_W-1:0]     acc_cap;
   logic [3:0]                          digit;

   assign digit    = 4'(in_byte - hmbp_pkg::CHAR_ZERO);
   assign acc_cap  = hmbp_pkg::LEN_PROD_W'(1) << hmbp_pkg::LENGTH_BITS;
   // length_value * 10 + digit
   assign acc_prod = hmbp_pkg::LEN_PROD_W'(cur.length_value) * hmbp_pkg::LEN_PROD_W'(10)
                   + hmbp_pkg::LEN_PROD_W'(digit);
   assign key_hit  = !cur.name_mismatch
                   && (cur.name_match_pos == hmbp_pkg::KEY_POS_W'(hmbp_pkg::KEY_LEN));

   always_comb begin
      nxt  = cur;
      err  = hmbp_pkg::ERR_NONE;
      tok  = 1'b0;
      pkt  = 1'b0;
      part = hmbp_pkg::PART_BODY;

      unique case (cur.parse_state)
         hmbp_pkg::ST_START: begin
            part = hmbp_pkg::PART_PROTOCOL;
            if (hmbp_pkg::is_cap(in_byte)) nxt.parse_state = hmbp_pkg::ST_PROTO;
            else err = hmbp_pkg::ERR_PROTO_START;
         end
         hmbp_pkg::ST_PROTO: begin
            part = hmbp_pkg::PART_PROTOCOL;
            if (in_byte == hmbp_pkg::CHAR_SPACE) begin
               tok = 1'b1;
               nxt.parse_state = hmbp_pkg::ST_METHOD;
               nxt.at_token_start = 1'b1;
            end else if (!hmbp_pkg::is_cap_dig_us(in_byte)) begin
               err = hmbp_pkg::ERR_PROTO_CHAR;
            end
         end
         hmbp_pkg::ST_METHOD: begin
            part = hmbp_pkg::PART_METHOD;
            if (cur.at_token_start) begin
               if (hmbp_pkg::is_cap(in_byte)) nxt.at_token_start = 1'b0;
               else err = hmbp_pkg::ERR_METHOD_START;
            end else if (in_byte == hmbp_pkg::CHAR_CR) begin
               nxt.parse_state = hmbp_pkg::ST_METHOD_LF;
            end else if (!hmbp_pkg::is_cap_dig_us(in_byte)) begin
               err = hmbp_pkg::ERR_METHOD_CHAR;
            end
         end
         hmbp_pkg::ST_METHOD_LF, hmbp_pkg::ST_VALUE_LF: begin
            part = (cur.parse_state == hmbp_pkg::ST_METHOD_LF) ? hmbp_pkg::PART_METHOD
                                                                : hmbp_pkg::PART_VALUE;
            if (in_byte == hmbp_pkg::CHAR_LF) begin
               tok = 1'b1;
               nxt.parse_state = hmbp_pkg::ST_NAME;
               nxt.at_token_start = 1'b1;
            end else begin
               err = hmbp_pkg::ERR_NO_LF;
            end
         end
         hmbp_pkg::ST_NAME: begin
            part = hmbp_pkg::PART_NAME;
            if (cur.at_token_start) begin
               if (hmbp_pkg::is_letter(in_byte)) begin
                  nxt.at_token_start = 1'b0;
                  nxt.name_mismatch  = (in_byte != hmbp_pkg::LENGTH_KEY[0]);
                  nxt.name_match_pos = hmbp_pkg::KEY_POS_W'(1);
               end else if (in_byte == hmbp_pkg::CHAR_CR) begin
                  // blank line: start of header end
                  part = hmbp_pkg::PART_HDR_END;
                  nxt.at_token_start = 1'b0;
                  nxt.parse_state = hmbp_pkg::ST_END_LF;
               end else begin
                  err = hmbp_pkg::ERR_NAME_START;
               end
            end else if (hmbp_pkg::is_name_char(in_byte)) begin
               if (cur.name_match_pos >= hmbp_pkg::KEY_POS_W'(hmbp_pkg::KEY_LEN)) begin
                  nxt.name_mismatch = 1'b1;
               end else begin
                  if (in_byte != hmbp_pkg::LENGTH_KEY[cur.name_match_pos])
                     nxt.name_mismatch = 1'b1;
                  nxt.name_match_pos = cur.name_match_pos + 1'b1;
               end
            end else if (in_byte == hmbp_pkg::CHAR_COLON) begin
               if (key_hit && cur.length_seen) begin
                  err = hmbp_pkg::ERR_DUP_LENGTH;
               end else begin
                  if (key_hit) nxt.length_seen = 1'b1;
                  nxt.value_is_length = key_hit;
                  nxt.length_value    = '0;
                  nxt.value_bad       = 1'b0;
                  nxt.parse_state     = hmbp_pkg::ST_COLON_SP;
               end
            end else begin
               err = hmbp_pkg::ERR_NAME_CHAR;
            end
         end
         hmbp_pkg::ST_COLON_SP: begin
            part = hmbp_pkg::PART_NAME;
            if (in_byte == hmbp_pkg::CHAR_SPACE) begin
               tok = 1'b1;
               nxt.parse_state = hmbp_pkg::ST_VALUE;
            end else begin
               err = hmbp_pkg::ERR_NO_SPACE;
            end
         end
         hmbp_pkg::ST_VALUE: begin
            part = hmbp_pkg::PART_VALUE;
            if (hmbp_pkg::is_printable(in_byte)) begin
               if (cur.value_is_length) begin
                  if (!hmbp_pkg::is_digit(in_byte)) begin
                     nxt.value_bad = 1'b1;
                  end else if (!cur.length_value[hmbp_pkg::LENGTH_BITS]) begin
                     // accumulator saturates at 2^LENGTH_BITS
                     if (acc_prod > acc_cap)
                        nxt.length_value = hmbp_pkg::LEN_ACC_W'(acc_cap);
                     else
                        nxt.length_value = hmbp_pkg::LEN_ACC_W'(acc_prod);
                  end
               end
            end else if (in_byte == hmbp_pkg::CHAR_CR) begin
               if (cur.value_is_length) begin
                  if (cur.value_bad || (cur.length_value == '0)
                      || (32'(cur.length_value) > 32'(max_body_length)))
                     err = hmbp_pkg::ERR_BAD_LENGTH;
                  else
                     nxt.body_remaining = cur.length_value[hmbp_pkg::LENGTH_BITS-1:0];
               end
               nxt.value_is_length = 1'b0;
               nxt.parse_state = hmbp_pkg::ST_VALUE_LF;
            end else begin
               err = hmbp_pkg::ERR_VALUE_CHAR;
            end
         end
         hmbp_pkg::ST_END_LF: begin
            part = hmbp_pkg::PART_HDR_END;
            if (in_byte == hmbp_pkg::CHAR_LF) begin
               tok = 1'b1;
               if (cur.length_seen) begin
                  nxt.parse_state = hmbp_pkg::ST_BODY;
               end else begin
                  pkt = 1'b1;
                  nxt = hmbp_pkg::PARSER_RESET;
               end
            end else begin
               err = hmbp_pkg::ERR_NO_LF;
            end
         end
         default: begin
            part = hmbp_pkg::PART_BODY;
            if (cur.body_remaining <= hmbp_pkg::LENGTH_BITS'(1)) begin
               tok = 1'b1;
               pkt = 1'b1;
               nxt = hmbp_pkg::PARSER_RESET;
            end else begin
               nxt.body_remaining = cur.body_remaining - 1'b1;
            end
         end
      endcase

      // any error drops back to the start state
      if (err != hmbp_pkg::ERR_NONE) begin
         tok = 1'b0;
         pkt = 1'b0;
         nxt = hmbp_pkg::PARSER_RESET;
      end
   end

   assign res.out_byte   = in_byte;
   assign res.part       = part;
   assign res.token_end  = tok;
   assign res.packet_end = pkt;
   assign res.error_code = err;

endmodule

// ----- rtl/header_message_byte_parser_core.sv -----
// header_message_byte_parser_core: top level of the header message byte parser
// depends on hmbp_pkg and hmbp_step

// Checks a text message one byte per transaction: protocol name, space, method, CRLF,
// "name: value" CRLF header lines, a blank CRLF, then a body whose length comes from
// the content-length header. Every accepted byte yields exactly one response
// transaction carrying the echoed byte, its part, token and packet end marks and an
// error code; any error sends the parser back to its start state. Throughput is one
// byte per clock while req_stall is low: the whole per-byte update (state decode, key
// match and the multiply-by-ten digit accumulate) is combinational between the parser
// state register and the response register. The response side has a two-entry buffer
// (output register plus skid slot): a response parks in the skid slot while the output
// is stalled, so a byte is taken while a finished response is still waiting; req_stall
// rises only once both entries are full. max_body_length may be written only while the
// block is idle; it resets to 65535. No clearing pass is needed after reset.

module header_message_byte_parser_core (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_wr_en,
   input  logic [hmbp_pkg::MAX_LEN_W-1:0] csr_wr_data,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_in_byte,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_out_byte,
   output logic [2:0]                     rsp_part,
   output logic                           rsp_token_end,
   output logic                           rsp_packet_end,
   output logic [3:0]                     rsp_error_code
);

   // configuration register
   logic [hmbp_pkg::MAX_LEN_W-1:0] max_len_ff;

   // parser state
   hmbp_pkg::parser_type parser_ff;
   hmbp_pkg::parser_type parser_in;

   // result of the byte currently presented
   hmbp_pkg::result_type step_res;

   // response buffer: output register and skid slot
   logic                 out_valid_ff, out_valid_in;
   hmbp_pkg::result_type out_data_ff,  out_data_in;
   logic                 skid_valid_ff, skid_valid_in;
   hmbp_pkg::result_type skid_data_ff,  skid_data_in;

   logic req_accept;
   logic out_free;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   // output register can take new data this cycle
   assign out_free   = !out_valid_ff || !rsp_stall;

   hmbp_step u_step (
      .in_byte         (req_in_byte),
      .max_body_length (max_len_ff),
      .cur             (parser_ff),
      .nxt             (parser_in),
      .res             (step_res)
   );

   // response buffer steering
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // drain the skid slot first; no request is taken while it is full
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = req_accept;
            out_data_in  = step_res;
         end
      end else if (req_accept) begin
         // output register is stalled, park the new response
         skid_valid_in = 1'b1;
         skid_data_in  = step_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff    <= '1;
         parser_ff     <= hmbp_pkg::PARSER_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) max_len_ff <= csr_wr_data;
         if (req_accept) parser_ff <= parser_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_byte   = out_data_ff.out_byte;
   assign rsp_part       = out_data_ff.part;
   assign rsp_token_end  = out_data_ff.token_end;
   assign rsp_packet_end = out_data_ff.packet_end;
   assign rsp_error_code = out_data_ff.error_code;

endmodule

// ----- rtl/hmbp_checker.sv -----
// hmbp_checker: port-level assertions for header_message_byte_parser_core, with its bind
// depends on hmbp_pkg and header_message_byte_parser_core

module hmbp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic [2:0] rsp_part,
   input logic       rsp_token_end,
   input logic       rsp_packet_end,
   input logic [3:0] rsp_error_code
);

   // a message only ends on a byte that also ends a token
   a_packet_end_is_token_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_end |-> rsp_token_end)
      else $error("packet end without token end");

   // an error response never carries token or packet marks
   a_error_clears_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != hmbp_pkg::ERR_NONE)
      |-> !rsp_token_end && !rsp_packet_end)
      else $error("marks set on error response");

   // after every accepted byte a response is valid on the next cycle
   a_accept_gives_response: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

   // input stalls only while a response is already waiting
   a_stall_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty response side");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
      && $stable(rsp_error_code) && $stable(rsp_part))
      else $error("stalled response changed");

endmodule

bind header_message_byte_parser_core hmbp_checker u_hmbp_checker (.*);

// ----- tb/sv/hmbp_checker.sv -----
// hmbp_scoreboard: watches the request, response and csr ports of the header message byte parser
// predicts one response per accepted byte and compares it field by field; depends on hmbp_pkg

module hmbp_scoreboard (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [hmbp_pkg::MAX_LEN_W-1:0] csr_wr_data,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [7:0]                     req_in_byte,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [7:0]                     rsp_out_byte,
   input  logic [2:0]                     rsp_part,
   input  logic                           rsp_token_end,
   input  logic                           rsp_packet_end,
   input  logic [3:0]                     rsp_error_code,
   output int                             mismatch_count,
   output int                             outstanding
);

   localparam logic [8*hmbp_pkg::KEY_LEN-1:0] KEY_TEXT = "content-length";
   localparam int ACC_CAP = 1 << hmbp_pkg::LENGTH_BITS;

   // predicted parser state
   hmbp_pkg::parse_state_type        ps;
   logic                             at_start;
   logic                             len_seen;
   logic [hmbp_pkg::KEY_POS_W-1:0]   key_pos;
   logic                             key_miss;
   logic                             val_is_len;
   logic [hmbp_pkg::LEN_ACC_W-1:0]   len_acc;
   logic                             val_bad;
   logic [hmbp_pkg::LENGTH_BITS-1:0] body_left;
   logic [hmbp_pkg::MAX_LEN_W-1:0]   max_len;

   hmbp_pkg::result_type             expected_rsp_q[$];
   int                               errors = 0;

   function automatic logic upper(input logic [7:0] c);
      return c >= "A" && c <= "Z";
   endfunction

   function automatic logic dec(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic alpha(input logic [7:0] c);
      return upper(c) || (c >= "a" && c <= "z");
   endfunction

   function automatic logic [7:0] key_char(input int pos);
      return KEY_TEXT[8*(hmbp_pkg::KEY_LEN-1-pos) +: 8];
   endfunction

   function automatic logic [2:0] part_for_state(input hmbp_pkg::parse_state_type s);
      case (s)
         hmbp_pkg::ST_START, hmbp_pkg::ST_PROTO:     return hmbp_pkg::PART_PROTOCOL;
         hmbp_pkg::ST_METHOD, hmbp_pkg::ST_METHOD_LF: return hmbp_pkg::PART_METHOD;
         hmbp_pkg::ST_NAME, hmbp_pkg::ST_COLON_SP:   return hmbp_pkg::PART_NAME;
         hmbp_pkg::ST_VALUE, hmbp_pkg::ST_VALUE_LF:  return hmbp_pkg::PART_VALUE;
         hmbp_pkg::ST_END_LF:                        return hmbp_pkg::PART_HDR_END;
         default:                                    return hmbp_pkg::PART_BODY;
      endcase
   endfunction

   function automatic void restart_message();
      ps         = hmbp_pkg::ST_START;
      at_start   = 1'b0;
      len_seen   = 1'b0;
      key_pos    = '0;
      key_miss   = 1'b0;
      val_is_len = 1'b0;
      len_acc    = '0;
      val_bad    = 1'b0;
      body_left  = '0;
   endfunction

   // advance the predicted parser by one byte and form its response
   task automatic parse_byte(input logic [7:0] c, output hmbp_pkg::result_type r);
      logic [2:0] part_v;
      logic       tok;
      logic       pkt;
      logic [3:0] err;
      logic       is_key;
      int         acc;
      part_v = part_for_state(ps);
      tok    = 1'b0;
      pkt    = 1'b0;
      err    = hmbp_pkg::ERR_NONE;
      case (ps)
         hmbp_pkg::ST_START: begin
            if (upper(c)) ps = hmbp_pkg::ST_PROTO;
            else err = hmbp_pkg::ERR_PROTO_START;
         end
         hmbp_pkg::ST_PROTO: begin
            if (c == hmbp_pkg::CHAR_SPACE) begin
               tok = 1'b1;
               ps = hmbp_pkg::ST_METHOD;
               at_start = 1'b1;
            end else if (!(upper(c) || dec(c) || c == "_")) err = hmbp_pkg::ERR_PROTO_CHAR;
         end
         hmbp_pkg::ST_METHOD: begin
            if (at_start) begin
               if (upper(c)) at_start = 1'b0;
               else err = hmbp_pkg::ERR_METHOD_START;
            end else if (c == hmbp_pkg::CHAR_CR) ps = hmbp_pkg::ST_METHOD_LF;
            else if (!(upper(c) || dec(c) || c == "_")) err = hmbp_pkg::ERR_METHOD_CHAR;
         end
         hmbp_pkg::ST_METHOD_LF, hmbp_pkg::ST_VALUE_LF: begin
            if (c == hmbp_pkg::CHAR_LF) begin
               tok = 1'b1;
               ps = hmbp_pkg::ST_NAME;
               at_start = 1'b1;
            end else err = hmbp_pkg::ERR_NO_LF;
         end
         hmbp_pkg::ST_NAME: begin
            if (at_start) begin
               if (alpha(c)) begin
                  at_start = 1'b0;
                  key_miss = (c != key_char(0));
                  key_pos = hmbp_pkg::KEY_POS_W'(1);
               end else if (c == hmbp_pkg::CHAR_CR) begin
                  // blank line: the CR already belongs to the header end
                  part_v = hmbp_pkg::PART_HDR_END;
                  at_start = 1'b0;
                  ps = hmbp_pkg::ST_END_LF;
               end else err = hmbp_pkg::ERR_NAME_START;
            end else if (alpha(c) || dec(c) || c == "_" || c == "-") begin
               if (key_pos >= hmbp_pkg::KEY_LEN) key_miss = 1'b1;
               else begin
                  if (c != key_char(key_pos)) key_miss = 1'b1;
                  key_pos = key_pos + 1'b1;
               end
            end else if (c == hmbp_pkg::CHAR_COLON) begin
               is_key = !key_miss && key_pos == hmbp_pkg::KEY_LEN;
               if (is_key && len_seen) err = hmbp_pkg::ERR_DUP_LENGTH;
               else begin
                  if (is_key) len_seen = 1'b1;
                  val_is_len = is_key;
                  len_acc = '0;
                  val_bad = 1'b0;
                  ps = hmbp_pkg::ST_COLON_SP;
               end
            end else err = hmbp_pkg::ERR_NAME_CHAR;
         end
         hmbp_pkg::ST_COLON_SP: begin
            if (c == hmbp_pkg::CHAR_SPACE) begin
               tok = 1'b1;
               ps = hmbp_pkg::ST_VALUE;
            end else err = hmbp_pkg::ERR_NO_SPACE;
         end
         hmbp_pkg::ST_VALUE: begin
            if (c >= 8'h20 && c <= 8'h7E) begin
               if (val_is_len) begin
                  if (!dec(c)) val_bad = 1'b1;
                  else if (len_acc < ACC_CAP) begin
                     acc = int'(len_acc) * 10 + int'(c - hmbp_pkg::CHAR_ZERO);
                     len_acc = (acc > ACC_CAP) ? hmbp_pkg::LEN_ACC_W'(ACC_CAP)
                                               : hmbp_pkg::LEN_ACC_W'(acc);
                  end
               end
            end else if (c == hmbp_pkg::CHAR_CR) begin
               if (val_is_len) begin
                  if (val_bad || len_acc == 0 || len_acc > max_len)
                     err = hmbp_pkg::ERR_BAD_LENGTH;
                  else body_left = len_acc[hmbp_pkg::LENGTH_BITS-1:0];
               end
               if (err == hmbp_pkg::ERR_NONE) begin
                  val_is_len = 1'b0;
                  ps = hmbp_pkg::ST_VALUE_LF;
               end
            end else err = hmbp_pkg::ERR_VALUE_CHAR;
         end
         hmbp_pkg::ST_END_LF: begin
            if (c == hmbp_pkg::CHAR_LF) begin
               tok = 1'b1;
               if (len_seen) ps = hmbp_pkg::ST_BODY;
               else begin
                  pkt = 1'b1;
                  restart_message();
               end
            end else err = hmbp_pkg::ERR_NO_LF;
         end
         default: begin
            if (body_left <= 1) begin
               tok = 1'b1;
               pkt = 1'b1;
               restart_message();
            end else body_left = body_left - 1'b1;
         end
      endcase
      if (err != hmbp_pkg::ERR_NONE) begin
         tok = 1'b0;
         pkt = 1'b0;
         restart_message();
      end
      r = '{out_byte: c, part: part_v, token_end: tok, packet_end: pkt, error_code: err};
   endtask

   always @(posedge clock) begin
      hmbp_pkg::result_type want;
      hmbp_pkg::result_type got;
      if (reset) begin
         restart_message();
         max_len = '1;
         expected_rsp_q.delete();
         outstanding <= 0;
         mismatch_count <= errors;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{out_byte: rsp_out_byte, part: rsp_part, token_end: rsp_token_end,
                    packet_end: rsp_packet_end, error_code: rsp_error_code};
            if (expected_rsp_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected response: byte %02h part %0d tok %0b pkt %0b err %0d",
                           got.out_byte, got.part, got.token_end, got.packet_end,
                           got.error_code);
            end else begin
               want = expected_rsp_q.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display({"response mismatch: expected byte %02h part %0d tok %0b ",
                               "pkt %0b err %0d, got byte %02h part %0d tok %0b pkt %0b ",
                               "err %0d"},
                              want.out_byte, want.part, want.token_end, want.packet_end,
                              want.error_code, got.out_byte, got.part, got.token_end,
                              got.packet_end, got.error_code);
               end
            end
         end
         if (csr_wr_en) max_len = csr_wr_data;
         if (req_valid && !req_stall) begin
            parse_byte(req_in_byte, want);
            expected_rsp_q = {expected_rsp_q, want};
         end
         outstanding <= expected_rsp_q.size();
         mismatch_count <= errors;
      end
   end

endmodule

// ----- tb/sv/header_message_byte_parser_core_tb.sv -----
// header_message_byte_parser_core_tb: stimulus and verdict for the header message byte parser
// drives message byte streams with random gaps and stalls; depends on hmbp_pkg and hmbp_scoreboard

module header_message_byte_parser_core_tb;

   // generous bound on the length of a correct run
   localparam int CYCLE_LIMIT = 400000;
   // bytes per random phase, one phase per max_body_length setting
   localparam int PHASE_BYTES = 175;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_wr_en = 1'b0;
   logic [hmbp_pkg::MAX_LEN_W-1:0] csr_wr_data = '0;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [7:0]                     req_in_byte = 8'h00;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [7:0]                     rsp_out_byte;
   logic [2:0]                     rsp_part;
   logic                           rsp_token_end;
   logic                           rsp_packet_end;
   logic [3:0]                     rsp_error_code;
   int                             mismatch_count;
   int                             outstanding;

   int                             cycles = 0;
   int                             bytes_sent = 0;
   int                             cur_max = 65535;  // mirror of max_body_length for lengths
   bit                             tx_quiet = 1'b0;  // sender sends back to back
   bit                             rx_quiet = 1'b0;  // receiver never stalls
   int                             stall_left = 0;
   int                             stall_draw;
   logic [7:0]                     msg_bytes[$];

   header_message_byte_parser_core dut (.*);

   hmbp_scoreboard u_scoreboard (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // response side: after each transaction draw a random stall length and hold stall for it
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_draw = rx_quiet ? 0 : $urandom_range(0, 15);
         stall_left <= stall_draw;
         rsp_stall <= (stall_draw != 0);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end
   end

   // one byte transaction, preceded by a random idle gap
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_message();
      foreach (msg_bytes[i]) send_byte(msg_bytes[i]);
   endtask

   // stop sending, wait until every response is back, then let the pipe settle
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_len(input int v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= hmbp_pkg::MAX_LEN_W'(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_max = v;
   endtask

   // append one byte to the message under construction
   function automatic void add_byte(input logic [7:0] b);
      msg_bytes = {msg_bytes, b};
   endfunction

   function automatic void put_text(input string s);
      foreach (s[i]) add_byte(s[i]);
   endfunction

   function automatic logic [7:0] pick_upper();
      return 8'("A" + $urandom_range(0, 25));
   endfunction

   // protocol and method tokens: capital first, then capitals, digits, underscore
   function automatic void put_token();
      int n;
      n = $urandom_range(0, 5);
      add_byte(pick_upper());
      repeat (n) begin
         case ($urandom_range(0, 2))
            0:       add_byte(pick_upper());
            1:       add_byte(8'("0" + $urandom_range(0, 9)));
            default: add_byte("_");
         endcase
      end
   endfunction

   function automatic void put_plain_name();
      int n;
      n = $urandom_range(0, 6);
      add_byte($urandom_range(0, 1) ? pick_upper() : 8'("a" + $urandom_range(0, 25)));
      repeat (n) begin
         case ($urandom_range(0, 4))
            0:       add_byte(pick_upper());
            1:       add_byte(8'("a" + $urandom_range(0, 25)));
            2:       add_byte(8'("0" + $urandom_range(0, 9)));
            3:       add_byte("_");
            default: add_byte("-");
         endcase
      end
   endfunction

   // content-length value text; body gets the length when the value is acceptable
   function automatic string length_text(output int body);
      int top;
      int k;
      top = (cur_max < 24) ? cur_max : 24;
      k = $urandom_range(0, 9);
      body = 0;
      case (k)
         7: return $urandom_range(0, 1) ? "0" : "";
         8: return $urandom_range(0, 1) ? $sformatf("%0dx", $urandom_range(1, 9)) : " 5";
         9: begin
            // just above the limit, or past what the counter can hold
            if (cur_max < 65535) return $sformatf("%0d", cur_max + 1);
            return $urandom_range(0, 1) ? "65536" : "123456789";
         end
         default: begin
            body = $urandom_range(1, top);
            // a single leading zero must not change the value
            return (k == 6) ? $sformatf("0%0d", body) : $sformatf("%0d", body);
         end
      endcase
   endfunction

   // well-formed message with random content; sometimes noise ahead of it,
   // a repeated content-length, or one byte overwritten anywhere
   task automatic build_message();
      int    n_hdr;
      int    body_len;
      int    val_body;
      int    n;
      bit    len_used;
      string val;
      msg_bytes.delete();
      body_len = 0;
      len_used = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 6);
         repeat (n) add_byte(8'($urandom_range(0, 255)));
      end
      put_token();
      put_text(" ");
      put_token();
      put_text("\r\n");
      n_hdr = $urandom_range(0, 3);
      repeat (n_hdr) begin
         if ($urandom_range(0, 2) == 0 && (!len_used || $urandom_range(0, 5) == 0)) begin
            put_text("content-length: ");
            val = length_text(val_body);
            if (!len_used) body_len = val_body;
            len_used = 1'b1;
            put_text(val);
         end else begin
            // near misses of the length key must be taken as ordinary headers
            case ($urandom_range(0, 7))
               0:       put_text("content-lengt");
               1:       put_text("content-lengthx");
               2:       put_text("Content-Length");
               3:       put_text("content-length-extra-long");
               default: put_plain_name();
            endcase
            put_text(": ");
            n = $urandom_range(0, 8);
            repeat (n) add_byte(8'($urandom_range(8'h20, 8'h7E)));
         end
         put_text("\r\n");
      end
      put_text("\r\n");
      repeat (body_len) add_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0)
         msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
   endtask

   initial begin
      int settings[4];
      int phase_end;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: byte extremes at the start state, a minimal message without
      // headers, and a one-byte body carrying the top byte value
      msg_bytes.delete();
      add_byte(8'h00);
      add_byte(8'hFF);
      put_text("A B\r\n\r\n");
      put_text("P M\r\ncontent-length: 1\r\n\r\n");
      add_byte(8'hFF);
      send_message();

      // limit extremes, a random small limit, and one just below the top
      settings[0] = 1;
      settings[1] = 65535;
      settings[2] = $urandom_range(2, 30);
      settings[3] = 65534;
      foreach (settings[p]) begin
         settle();
         write_max_len(settings[p]);
         phase_end = bytes_sent + PHASE_BYTES;
         while (bytes_sent < phase_end) begin
            // occasional stretches with no idling on either side
            tx_quiet = ($urandom_range(0, 4) == 0);
            rx_quiet <= ($urandom_range(0, 4) == 0);
            build_message();
            send_message();
         end
      end

      // drain: every response back, then room for any stray one
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/hmbp_pkg.sv
rtl/hmbp_step.sv
rtl/header_message_byte_parser_core.sv
rtl/hmbp_checker.sv
tb/sv/hmbp_checker.sv
tb/sv/header_message_byte_parser_core_tb.sv
